// ----- hdl/fourier_feature_generator_top_macros.svh -----
// Assertion macros shared by the checker of the Fourier feature generator.
`ifndef FOURIER_FEATURE_GENERATOR_TOP_MACROS_SVH
`define FOURIER_FEATURE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define FFG_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define FFG_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define FFG_CHECK_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ----- hdl/ffg_pkg.sv -----
// Shared constants and types of the Fourier feature generator.
package ffg_pkg;

  // Feature sizes and formats.
  localparam int MAX_HALF_DIM = 64;
  localparam int OUT_WIDTH    = 16;
  localparam int IDX_W        = $clog2(MAX_HALF_DIM);
  localparam int HD_W         = 7;
  localparam int VAL_W        = 17;
  localparam int FREQ_W       = 32;
  localparam int RATIO_W      = 32;
  localparam int PHASE_W      = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 2;

  // Quarter-sine arithmetic: Q30 values with headroom up to about 1.6.
  localparam int QW        = 31;
  localparam int QS_STAGES = 6;
  localparam logic [QW-1:0] Q30_ONE = QW'(1073741824);
  localparam logic [QW-1:0] SC9     = QW'(172272);
  // Horner coefficients in order of use: x^7, x^5, x^3 and x^1 terms.
  localparam logic [QW-1:0] HORNER_C [1:4] = '{
    QW'(5026995), QW'(85569306), QW'(693598668), QW'(1686629713)
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_START = 2'd0,
    CFG_FREQ_RATIO = 2'd1,
    CFG_HALF_DIM   = 2'd2
  } cfg_index_t;

  // Quadrant of the phase, from its top two bits.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // One frequency step leaving the generator.
  typedef struct packed {
    logic              valid;
    logic [VAL_W-1:0]  val;
    logic [FREQ_W-1:0] freq;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } ffg_item_t;

  // Side data that travels beside the sine pipelines.
  typedef struct packed {
    quad_t            quad;
    logic [IDX_W-1:0] idx;
    logic             last;
  } ffg_tag_t;

endpackage

// ----- hdl/ffg_freq_gen.sv -----
// Frequency sequencer: holds one input value and steps through its frequencies.
module ffg_freq_gen import ffg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VAL_W-1:0]   value,
  input  logic [FREQ_W-1:0]  freq_start,
  input  logic [RATIO_W-1:0] freq_ratio,
  input  logic [HD_W-1:0]    half_dim,
  output ffg_item_t          item
);

  logic                      busy;
  logic [VAL_W-1:0]          val;
  logic [FREQ_W-1:0]         freq;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          nlast;
  logic [IDX_W-1:0]          nlast_next;
  logic [FREQ_W-1:0]         freq_next;
  logic [FREQ_W+RATIO_W-1:0] prod;
  logic [FREQ_W+RATIO_W-1:0] rounded;
  logic                      is_last;
  logic                      take;

  // Index of the final frequency, from half_dim clamped to 1..MAX_HALF_DIM.
  always_comb begin
    if (half_dim == '0) begin
      nlast_next = '0;
    end else if (half_dim > HD_W'(MAX_HALF_DIM)) begin
      nlast_next = IDX_W'(MAX_HALF_DIM - 1);
    end else begin
      nlast_next = IDX_W'(half_dim - HD_W'(1));
    end
  end

  // Next frequency: UQ16.16 times UQ8.24, rounded, saturated to 32 bits.
  assign prod    = freq * freq_ratio;
  assign rounded = prod + (FREQ_W+RATIO_W)'(1 << 23);
  always_comb begin
    if (|rounded[FREQ_W+RATIO_W-1:FREQ_W+24]) begin
      freq_next = '1;
    end else begin
      freq_next = rounded[FREQ_W+23:24];
    end
  end

  // A new value is taken when the slot is free or its final step leaves now.
  assign is_last  = (idx == nlast);
  assign in_ready = en && (!busy || is_last);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (en && busy && is_last) begin
      busy <= 1'b0;
    end
  end

  // Step state; the value and count load on a new beat.
  always_ff @(posedge clk) begin
    if (take) begin
      val   <= value;
      freq  <= freq_start;
      idx   <= '0;
      nlast <= nlast_next;
    end else if (en && busy) begin
      idx  <= idx + IDX_W'(1);
      freq <= freq_next;
    end
  end

  assign item.valid = busy;
  assign item.val   = val;
  assign item.freq  = freq;
  assign item.idx   = idx;
  assign item.last  = is_last;

endmodule

// ----- hdl/ffg_qsine.sv -----
// Pipelined quarter-wave sine: odd polynomial through x^9 in Horner form.
module ffg_qsine import ffg_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] x,
  output logic [QW-1:0] s
);

  logic [QW-1:0]   xs  [0:4];
  logic [QW-1:0]   x2s [0:3];
  logic [QW-1:0]   ps  [1:4];
  logic [2*QW-1:0] sq;
  logic [2*QW-1:0] fp;

  // First stage: square of the argument, back to Q30.
  assign sq = x * x;
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= x;
      x2s[0] <= sq[2*QW-2:QW-1];
    end
  end

  // Horner stages: p = C - p * x^2, one multiply per stage.
  for (genvar k = 1; k <= 4; k++) begin : g_horner
    logic [QW-1:0]   pin;
    logic [2*QW-1:0] pm;

    if (k == 1) begin : g_first
      assign pin = SC9;
    end else begin : g_rest
      assign pin = ps[k-1];
    end

    assign pm = pin * x2s[k-1];

    always_ff @(posedge clk) begin
      if (en) begin
        ps[k] <= HORNER_C[k] - pm[2*QW-2:QW-1];
        xs[k] <= xs[k-1];
      end
    end

    if (k < 4) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          x2s[k] <= x2s[k-1];
        end
      end
    end
  end

  // Last stage: multiply by x once more.
  assign fp = ps[4] * xs[4];
  always_ff @(posedge clk) begin
    if (en) begin
      s <= fp[2*QW-2:QW-1];
    end
  end

endmodule

// ----- hdl/fourier_feature_generator_top.sv -----
// Top level of the Fourier feature generator: config, phase, sine lanes, output.
//
// Usage: each beat on the input channel (in_valid/in_ready, field value,
// UQ1.16) produces half_dim result beats on the output channel
// (out_valid/out_ready), one per frequency, carrying feature_index, cos_out,
// sin_out (Q1.15) and last on the final beat of the set.
// Frequencies start at freq_start and grow by freq_ratio per step.
// Configuration is written through cfg_wen, cfg_index and cfg_data while the
// block is idle: index 0 is freq_start, 1 is freq_ratio, 2 is half_dim.
// Throughput: one result per cycle unless the output stalls; an input gives
// half_dim results (clamped to 1..64), set by the frequency sequencer, which
// issues one step per cycle while not stalled and takes the next value in
// the cycle its final step moves on.
// The datapath is an 8-stage pipeline behind the sequencer, with the output
// register as its last stage.
// Reset clears all valid bits and loads freq_start = 1.0, freq_ratio = 1.0,
// half_dim = 64. While a result is pending and the receiver holds out_ready
// low, the whole pipeline and the sequencer freeze, and the result is held.
module fourier_feature_generator_top import ffg_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VAL_W-1:0]            value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [IDX_W-1:0]            feature_index,
  output logic signed [OUT_WIDTH-1:0] cos_out,
  output logic signed [OUT_WIDTH-1:0] sin_out,
  output logic                        last,
  input  logic                        cfg_wen,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  localparam int                   PROD_W = QW + OUT_WIDTH;
  localparam int                   MAG_W  = PROD_W + 1 - 30;
  localparam logic [OUT_WIDTH-1:0] AMP    = OUT_WIDTH'((1 << (OUT_WIDTH - 1)) - 1);

  logic [FREQ_W-1:0]         freq_start;
  logic [RATIO_W-1:0]        freq_ratio;
  logic [HD_W-1:0]           half_dim;
  logic                      en;
  ffg_item_t                 item;
  logic                      v1;
  logic [PHASE_W-1:0]        phase;
  ffg_tag_t                  tag1;
  logic [VAL_W+FREQ_W-1:0]   phase_prod;
  logic [QW-1:0]             xr;
  logic [QW-1:0]             xc;
  logic [QW-1:0]             sr;
  logic [QW-1:0]             sc;
  logic                      vq [0:QS_STAGES-1];
  ffg_tag_t                  tq [0:QS_STAGES-1];
  logic [OUT_WIDTH-1:0]      cos_next;
  logic [OUT_WIDTH-1:0]      sin_next;

  // Scale a quarter-sine value to the output amplitude, round, clamp, sign.
  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [QW-1:0] sv,
                                                  input logic neg);
    logic [PROD_W:0]      sum;
    logic [MAG_W-1:0]     mag;
    logic [OUT_WIDTH-1:0] res;
    sum = (PROD_W+1)'(sv) * (PROD_W+1)'(AMP) + (PROD_W+1)'(1 << 29);
    mag = sum[PROD_W:30];
    if (mag > MAG_W'(AMP)) begin
      res = AMP;
    end else begin
      res = mag[OUT_WIDTH-1:0];
    end
    if (neg) begin
      res = OUT_WIDTH'(0) - res;
    end
    return res;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_start <= FREQ_W'(65536);
      freq_ratio <= RATIO_W'(16777216);
      half_dim   <= HD_W'(MAX_HALF_DIM);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FREQ_START: freq_start <= cfg_data[FREQ_W-1:0];
        CFG_FREQ_RATIO: freq_ratio <= cfg_data[RATIO_W-1:0];
        CFG_HALF_DIM:   half_dim   <= cfg_data[HD_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is empty or drained.
  assign en = !out_valid || out_ready;

  ffg_freq_gen u_gen (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .freq_start (freq_start),
    .freq_ratio (freq_ratio),
    .half_dim   (half_dim),
    .item       (item)
  );

  // Phase stage: value times frequency, kept modulo one turn.
  assign phase_prod = item.val * item.freq;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      phase     <= phase_prod[PHASE_W-1:0];
      tag1.quad <= QUAD_0;
      tag1.idx  <= item.idx;
      tag1.last <= item.last;
    end
  end

  // Position inside the quadrant and its complement, both Q30.
  assign xr = {1'b0, phase[29:0]};
  assign xc = Q30_ONE - xr;

  ffg_qsine u_sin_r (
    .clk (clk),
    .en  (en),
    .x   (xr),
    .s   (sr)
  );

  ffg_qsine u_sin_c (
    .clk (clk),
    .en  (en),
    .x   (xc),
    .s   (sc)
  );

  // Valid bits and side data beside the sine lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QS_STAGES; k++) begin
        vq[k] <= 1'b0;
      end
    end else if (en) begin
      vq[0] <= v1;
      for (int k = 1; k < QS_STAGES; k++) begin
        vq[k] <= vq[k-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tq[0].quad <= quad_t'(phase[PHASE_W-1:PHASE_W-2]);
      tq[0].idx  <= tag1.idx;
      tq[0].last <= tag1.last;
      for (int k = 1; k < QS_STAGES; k++) begin
        tq[k] <= tq[k-1];
      end
    end
  end

  // Quadrant folding onto the two quarter-sine values.
  always_comb begin
    case (tq[QS_STAGES-1].quad)
      QUAD_0: begin
        cos_next = to_out(sc, 1'b0);
        sin_next = to_out(sr, 1'b0);
      end
      QUAD_1: begin
        cos_next = to_out(sr, 1'b1);
        sin_next = to_out(sc, 1'b0);
      end
      QUAD_2: begin
        cos_next = to_out(sc, 1'b1);
        sin_next = to_out(sr, 1'b1);
      end
      QUAD_3: begin
        cos_next = to_out(sr, 1'b0);
        sin_next = to_out(sc, 1'b1);
      end
      default: begin
        cos_next = '0;
        sin_next = '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq[QS_STAGES-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      feature_index <= tq[QS_STAGES-1].idx;
      last          <= tq[QS_STAGES-1].last;
      cos_out       <= cos_next;
      sin_out       <= sin_next;
    end
  end

endmodule

// ----- hdl/ffg_checker.sv -----
// Port-level checker for the Fourier feature generator, bound to its top level.
`include "fourier_feature_generator_top_macros.svh"

module ffg_checker import ffg_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [IDX_W-1:0]            feature_index,
  input logic signed [OUT_WIDTH-1:0] cos_out,
  input logic signed [OUT_WIDTH-1:0] sin_out,
  input logic                        last
);

  // A stalled result beat stays put.
  `FFG_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(feature_index) && $stable(cos_out) && $stable(sin_out) && $stable(last), "output beat changed while stalled")

  // A stalled output also stops input intake.
  `FFG_CHECK_IMP(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "input taken while output stalled")

  // Beats of one set follow each other with no gap and rising index.
  `FFG_CHECK_NEXT(a_index_step, out_valid && out_ready && !last, out_valid && (feature_index == IDX_W'($past(feature_index) + IDX_W'(1))), "feature index did not step by one")

  // A set that directly follows another starts at index zero.
  `FFG_CHECK_NEXT(a_index_restart, out_valid && out_ready && last, !out_valid || (feature_index == '0), "new set did not start at index zero")

  // Reset empties the output register.
  `FFG_CHECK_RESET(a_reset_empty, !out_valid, "output valid after reset")

endmodule

bind fourier_feature_generator_top ffg_checker u_ffg_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the Fourier feature generator top level.
`timescale 1ns / 100ps

module testbench import ffg_pkg::*;;

  // Odd Taylor terms of sin(pi*x/2) in Q30, used by the quarter-wave predictor.
  localparam longint unsigned K1_Q30   = 64'd1686629713;
  localparam longint unsigned K3_Q30   = 64'd693598668;
  localparam longint unsigned K5_Q30   = 64'd85569306;
  localparam longint unsigned K7_Q30   = 64'd5026995;
  localparam longint unsigned K9_Q30   = 64'd172272;
  localparam longint unsigned Q30_UNIT = 64'd1073741824;
  localparam longint unsigned AMP      = (64'd1 << (OUT_WIDTH - 1)) - 64'd1;
  localparam longint unsigned FREQ_SAT = 64'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [31:0]          ONE_Q16          = 32'h0001_0000;
  localparam logic [31:0]          ONE_Q24          = 32'h0100_0000;
  localparam logic [OUT_WIDTH-1:0] Q15_POS_FULL     = 16'h7FFF;
  localparam logic [OUT_WIDTH-1:0] Q15_NEG_FULL     = 16'h8001;
  localparam logic [OUT_WIDTH-1:0] Q15_ZERO         = 16'h0000;
  localparam int                   WATCHDOG_LIMIT   = 2000;

  // One result pair as the block should send it.
  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [OUT_WIDTH-1:0] cos_v;
    logic [OUT_WIDTH-1:0] sin_v;
    logic                 last;
  } feature_t;

  // One directed stimulus row: optional register load, then one value.
  typedef struct packed {
    bit                   cfg;
    logic [31:0]          start;
    logic [31:0]          ratio;
    logic [31:0]          hd;
    bit                   junk;
    logic [VAL_W-1:0]     val;
    bit                   typed;
    logic [OUT_WIDTH-1:0] cos_v;
    logic [OUT_WIDTH-1:0] sin_v;
  } probe_row_t;

  bit                          clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [VAL_W-1:0]            value;
  logic                        out_valid;
  logic                        out_ready;
  logic [IDX_W-1:0]            feature_index;
  logic signed [OUT_WIDTH-1:0] cos_out;
  logic signed [OUT_WIDTH-1:0] sin_out;
  logic                        last;
  logic                        cfg_wen;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;

  // Register copies used by the predictor.
  logic [FREQ_W-1:0]  freq_start_q = ONE_Q16;
  logic [RATIO_W-1:0] freq_ratio_q = ONE_Q24;
  logic [HD_W-1:0]    half_dim_q   = 7'd64;

  feature_t   expected_features [$];
  feature_t   head_feature;
  probe_row_t directed_rows [$];
  int         mismatch_count = 0;
  int         stall_cycles   = 0;
  int         snd_idle_pct   = 0;
  int         rcv_stall_pct  = 0;

  fourier_feature_generator_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .feature_index (feature_index),
    .cos_out       (cos_out),
    .sin_out       (sin_out),
    .last          (last),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock, low half first.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sine of a quarter turn scaled by x (Q30), by Horner evaluation.
  function automatic longint unsigned quarter_wave(input longint unsigned x);
    longint unsigned x2;
    longint unsigned p;
    x2 = (x * x) >> 30;
    p = K9_Q30;
    p = K7_Q30 - ((p * x2) >> 30);
    p = K5_Q30 - ((p * x2) >> 30);
    p = K3_Q30 - ((p * x2) >> 30);
    p = K1_Q30 - ((p * x2) >> 30);
    return (p * x) >> 30;
  endfunction

  // Round a Q30 magnitude to the output format, saturate, and apply the sign.
  function automatic logic [OUT_WIDTH-1:0] to_q15(input longint unsigned s, input bit neg);
    longint unsigned mag;
    mag = (s * AMP + (64'd1 << 29)) >> 30;
    if (mag > AMP) begin
      mag = AMP;
    end
    if (neg) begin
      mag = 64'd0 - mag;
    end
    return mag[OUT_WIDTH-1:0];
  endfunction

  // Queue every result pair that one accepted value should produce.
  function automatic void predict_features(input logic [VAL_W-1:0] v);
    int unsigned     n;
    int unsigned     i;
    longint unsigned freq;
    longint unsigned phase;
    longint unsigned r;
    longint unsigned s_r;
    longint unsigned s_c;
    feature_t        f;
    n = half_dim_q;
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_HALF_DIM) begin
      n = MAX_HALF_DIM;
    end
    freq = freq_start_q;
    for (i = 0; i < n; i++) begin
      if (i > 0) begin
        freq = (freq * freq_ratio_q + (64'd1 << 23)) >> 24;
        if (freq > FREQ_SAT) begin
          freq = FREQ_SAT;
        end
      end
      phase = (v * freq) & FREQ_SAT;
      r = phase & (Q30_UNIT - 64'd1);
      s_r = quarter_wave(r);
      s_c = quarter_wave(Q30_UNIT - r);
      f.idx = i[IDX_W-1:0];
      case (quad_t'(phase[31:30]))
        QUAD_0: begin
          f.cos_v = to_q15(s_c, 1'b0);
          f.sin_v = to_q15(s_r, 1'b0);
        end
        QUAD_1: begin
          f.cos_v = to_q15(s_r, 1'b1);
          f.sin_v = to_q15(s_c, 1'b0);
        end
        QUAD_2: begin
          f.cos_v = to_q15(s_c, 1'b1);
          f.sin_v = to_q15(s_r, 1'b1);
        end
        default: begin
          f.cos_v = to_q15(s_r, 1'b0);
          f.sin_v = to_q15(s_c, 1'b1);
        end
      endcase
      f.last = (i + 1 == n);
      expected_features.push_back(f);
    end
  endfunction

  function automatic void compare_field(input string field, input longint want,
                                        input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one value; on its beat, queue its results (optionally with fixed cos/sin).
  task automatic send_value(input logic [VAL_W-1:0] v, input bit typed,
                            input logic [OUT_WIDTH-1:0] cos_fix,
                            input logic [OUT_WIDTH-1:0] sin_fix);
    int first;
    int k;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    first = expected_features.size();
    predict_features(v);
    if (typed) begin
      for (k = first; k < expected_features.size(); k++) begin
        expected_features[k].cos_v = cos_fix;
        expected_features[k].sin_v = sin_fix;
      end
    end
    @(negedge clk);
  endtask

  // Stop offering values and wait until every queued result has come out.
  task automatic drain_features();
    in_valid <= 1'b0;
    while (expected_features.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write all three registers back to back; optionally poke the unused index too.
  task automatic load_registers(input logic [31:0] start, input logic [31:0] ratio,
                                input logic [31:0] hd, input bit junk);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_FREQ_START;
    cfg_data  <= start;
    @(negedge clk);
    cfg_index <= CFG_FREQ_RATIO;
    cfg_data  <= ratio;
    @(negedge clk);
    cfg_index <= CFG_HALF_DIM;
    cfg_data  <= hd;
    @(negedge clk);
    if (junk) begin
      cfg_index <= CFG_UNUSED_INDEX;
      cfg_data  <= '1;
      @(negedge clk);
    end
    cfg_wen <= 1'b0;
    freq_start_q = start;
    freq_ratio_q = ratio;
    half_dim_q   = hd[HD_W-1:0];
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return VAL_W'(1) << $urandom_range(VAL_W - 1);
      default: return VAL_W'($urandom_range((1 << VAL_W) - 1));
    endcase
  endfunction

  // Receiver: random stalls at the configured rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Result checker: every beat is compared with the oldest pending pair.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_features.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual index %0d", $time,
                 feature_index);
        mismatch_count++;
      end else begin
        head_feature = expected_features.pop_front();
        compare_field("feature_index", head_feature.idx, feature_index);
        compare_field("cos_out", $signed(head_feature.cos_v), cos_out);
        compare_field("sin_out", $signed(head_feature.sin_v), sin_out);
        compare_field("last", head_feature.last, last);
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int          ph;
    logic [31:0] start_w;
    logic [31:0] ratio_w;
    logic [31:0] hd_w;
    rst       = 1'b1;
    in_valid  = 1'b0;
    value     = '0;
    out_ready = 1'b0;
    cfg_wen   = 1'b0;
    cfg_index = CFG_FREQ_START;
    cfg_data  = '0;

    // Directed rows: cfg, start, ratio, half_dim, junk write, value, typed, cos, sin.
    directed_rows = '{
      // Reset settings: zero, one turn and each quarter turn.
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h00000, 1, Q15_POS_FULL, Q15_ZERO},
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h1FFFF, 0, Q15_ZERO, Q15_ZERO},
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h10000, 1, Q15_POS_FULL, Q15_ZERO},
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h08000, 1, Q15_NEG_FULL, Q15_ZERO},
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h04000, 1, Q15_ZERO, Q15_POS_FULL},
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h0C000, 1, Q15_ZERO, Q15_NEG_FULL},
      // Doubling frequencies over eight pairs.
      '{1, 32'h0000_4000, 32'h0200_0000, 32'd8, 0, 17'h00001, 0, Q15_ZERO, Q15_ZERO},
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h15555, 0, Q15_ZERO, Q15_ZERO},
      // All-ones registers; a zero half_dim still gives one pair.
      '{1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0, 17'h1FFFF, 0, Q15_ZERO, Q15_ZERO},
      // Half_dim above the maximum, frequency running into saturation.
      '{1, 32'h8000_0000, 32'hFFFF_FFFF, 32'd127, 0, 17'h12345, 0, Q15_ZERO, Q15_ZERO},
      // Zero ratio: every pair after the first has zero phase.
      '{1, 32'h0001_0000, 32'h0, 32'd5, 0, 17'h1ABCD, 0, Q15_ZERO, Q15_ZERO},
      // Zero start frequency; the write to the unused index must not land.
      '{1, 32'h0, 32'h0080_0000, 32'd65, 1, 17'h1FFFF, 1, Q15_POS_FULL, Q15_ZERO},
      '{0, 32'h0, 32'h0, 32'h0, 0, 17'h0AAAA, 1, Q15_POS_FULL, Q15_ZERO},
      // Saturated start pulled down by a ratio below one.
      '{1, 32'hFFFF_FFFF, 32'h00C0_0000, 32'd64, 0, 17'h1FFFF, 0, Q15_ZERO, Q15_ZERO},
      // Upper data bits of half_dim are dropped.
      '{1, ONE_Q16, ONE_Q24, 32'hFFFF_FF81, 0, 17'h0AAAA, 0, Q15_ZERO, Q15_ZERO},
      '{1, 32'h0000_0100, 32'h0120_0000, 32'd64, 1, 17'h1FFFF, 0, Q15_ZERO, Q15_ZERO}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling.
    foreach (directed_rows[k]) begin
      if (directed_rows[k].cfg) begin
        drain_features();
        load_registers(directed_rows[k].start, directed_rows[k].ratio,
                       directed_rows[k].hd, directed_rows[k].junk);
      end
      send_value(directed_rows[k].val, directed_rows[k].typed,
                 directed_rows[k].cos_v, directed_rows[k].sin_v);
    end

    // Random part: new register settings and a new idling pattern per phase.
    for (ph = 0; ph < 8; ph++) begin
      drain_features();
      case (ph % 4)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct  = 70;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 70;
        end
        default: begin
          snd_idle_pct  = 36;
          rcv_stall_pct = 36;
        end
      endcase
      case ($urandom_range(2))
        0:       start_w = $urandom;
        1:       start_w = $urandom_range(32'h0004_0000);
        default: start_w = ONE_Q16;
      endcase
      case ($urandom_range(3))
        0:       ratio_w = $urandom;
        1:       ratio_w = ONE_Q24;
        default: ratio_w = $urandom_range(32'h0200_0000, 32'h00C0_0000);
      endcase
      case ($urandom_range(3))
        0:       hd_w = $urandom_range(127);
        1:       hd_w = MAX_HALF_DIM;
        default: hd_w = $urandom_range(16, 1);
      endcase
      load_registers(start_w, ratio_w, hd_w, ph == 5);
      repeat (40) begin
        send_value(random_value(), 1'b0, Q15_ZERO, Q15_ZERO);
      end
    end

    // Let the last results drain, then give stray beats a chance to show up.
    drain_features();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
